// ===== sv/cae_pkg.sv =====
// ============================================================================
// cae_pkg - CIGAR alignment expander shared definitions
// Operation and element codes, table sizing, transaction structs and the
// sequencer state type.
// ============================================================================
package cae_pkg;

   // CIGAR table sizing
   localparam int MAX_ELEMENTS = 64;
   localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

   // Field widths
   localparam int COL_W  = 32;
   localparam int LEN_W  = 28;
   localparam int KIND_W = 4;
   localparam int BASE_W = 4;

   // Request operation codes
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_BASE   = 2'd2;

   // SAM CIGAR element codes
   localparam logic [KIND_W-1:0] KIND_M  = 4'd0;
   localparam logic [KIND_W-1:0] KIND_I  = 4'd1;
   localparam logic [KIND_W-1:0] KIND_D  = 4'd2;
   localparam logic [KIND_W-1:0] KIND_N  = 4'd3;
   localparam logic [KIND_W-1:0] KIND_S  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_EQ = 4'd7;
   localparam logic [KIND_W-1:0] KIND_X  = 4'd8;

   // Result status codes
   localparam logic STATUS_PLACED  = 1'b0;
   localparam logic STATUS_OVERRUN = 1'b1;

   typedef struct packed {
      logic [1:0]        operation;
      logic [30:0]       start_column;
      logic [KIND_W-1:0] element_kind;
      logic [LEN_W-1:0]  element_length;
      logic [BASE_W-1:0] base_nibble;
   } cae_req_type;

   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [BASE_W-1:0] out_base;
      logic              is_insertion;
      logic              insertion_last;
      logic              status;
   } cae_rsp_type;

   typedef enum logic {
      CAE_IDLE,
      CAE_WALK
   } cae_state_type;

endpackage

// ===== sv/cigar_alignment_expander_core.sv =====
// ============================================================================
// cigar_alignment_expander_core - CIGAR walk to reference columns
// Stores a read's CIGAR elements and assigns each read base a column.
// ============================================================================
// Usage:
//  - Request: a transaction is taken when start is high and busy is low.
//    req_item.operation selects start read, append CIGAR element or base.
//  - Start and append leave the sequencer idle; busy stays low and no result is made.
//  - A base transaction raises busy while the sequencer walks the CIGAR
//    table, one element per cycle through a single registered table read
//    port and one shared 32-bit column adder.
//  - For a base, the sequencer steps past every zero-length, D, N, H or P
//    element on the way and registers the result onto rsp_strobe; a new
//    base is taken only once the sequencer has returned to idle.
//  - Soft-clipped bases and bases past the end of the table behave as the
//    element walk dictates: S gives no result, overrun gives status 1.
//  - Results are shown for exactly one cycle with rsp_strobe high; the
//    receiver cannot stall, so every result is taken when it is shown.
//  - Reset (synchronous, active high) empties the table, zeroes the column
//    and returns the sequencer to idle. Table contents are not cleared.
// ============================================================================
module cigar_alignment_expander_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cae_pkg::cae_req_type req_item,
   output logic                 rsp_strobe,
   output cae_pkg::cae_rsp_type rsp_item
);
   import cae_pkg::*;

   // CIGAR table: {kind, length} per element
   logic [KIND_W+LEN_W-1:0] table_mem [MAX_ELEMENTS];
   logic [KIND_W+LEN_W-1:0] rdata_ff;
   logic                    wr_en;
   logic [IDX_W-1:0]        rd_addr;

   cae_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pointer_ff, pointer_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [COL_W-1:0] column_ff, column_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   cae_rsp_type      rsp_item_ff, rsp_item_in;

   logic             accept;
   logic             overrun;
   logic             skip;
   logic [KIND_W-1:0] ent_kind;
   logic [LEN_W-1:0] ent_len;
   logic             is_place, is_ins, is_clip, is_gap;
   logic [LEN_W-1:0] eff_remain, new_remain;
   logic             done;
   logic [COL_W-1:0] col_step;

   assign accept   = start && (state_ff == CAE_IDLE);
   assign ent_kind = rdata_ff[KIND_W+LEN_W-1:LEN_W];
   assign ent_len  = rdata_ff[LEN_W-1:0];
   assign is_place = (ent_kind == KIND_M) || (ent_kind == KIND_EQ) || (ent_kind == KIND_X);
   assign is_ins   = (ent_kind == KIND_I);
   assign is_clip  = (ent_kind == KIND_S);
   assign is_gap   = (ent_kind == KIND_D) || (ent_kind == KIND_N);
   assign overrun  = (pointer_ff >= count_ff);
   // element not entered yet and consumes no base: step past it
   assign skip     = (remain_ff == '0) &&
                     ((ent_len == '0) || !(is_place || is_ins || is_clip));
   assign eff_remain = (remain_ff == '0) ? ent_len : remain_ff;
   assign new_remain = eff_remain - LEN_W'(1);
   assign done       = (new_remain == '0);
   assign rd_addr    = pointer_in[IDX_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CAE_IDLE: begin
            if (accept && (req_item.operation == OP_BASE)) begin
               state_in = CAE_WALK;
            end
         end
         CAE_WALK: begin
            if (overrun || !skip) begin
               state_in = CAE_IDLE;
            end
         end
         default: state_in = CAE_IDLE;
      endcase
   end

   // Column step for the shared adder
   always_comb begin
      col_step = '0;
      if (state_ff == CAE_WALK && !overrun) begin
         if (skip) begin
            if (is_gap) begin
               col_step = COL_W'(ent_len);
            end
         end else if (is_place) begin
            col_step = COL_W'(1);
         end else if (is_ins && done) begin
            col_step = COL_W'(ent_len);
         end
      end
   end

   // Datapath and result updates
   always_comb begin
      count_in      = count_ff;
      pointer_in    = pointer_ff;
      remain_in     = remain_ff;
      column_in     = column_ff + col_step;
      base_in       = base_ff;
      wr_en         = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      unique case (state_ff)
         CAE_IDLE: begin
            if (accept) begin
               unique case (req_item.operation)
                  OP_START: begin
                     column_in  = {1'b0, req_item.start_column};
                     count_in   = '0;
                     pointer_in = '0;
                     remain_in  = '0;
                  end
                  OP_APPEND: begin
                     if (req_item.element_kind <= KIND_X &&
                         count_ff < CNT_W'(MAX_ELEMENTS)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_BASE: begin
                     base_in = req_item.base_nibble;
                  end
                  default: ;
               endcase
            end
         end
         CAE_WALK: begin
            if (overrun) begin
               rsp_strobe_in              = 1'b1;
               rsp_item_in.column         = column_ff;
               rsp_item_in.out_base       = base_ff;
               rsp_item_in.is_insertion   = 1'b0;
               rsp_item_in.insertion_last = 1'b0;
               rsp_item_in.status         = STATUS_OVERRUN;
            end else if (skip) begin
               pointer_in = pointer_ff + CNT_W'(1);
            end else begin
               remain_in = new_remain;
               if (done) begin
                  pointer_in = pointer_ff + CNT_W'(1);
               end
               if (is_place || is_ins) begin
                  rsp_strobe_in              = 1'b1;
                  rsp_item_in.column         = column_ff;
                  rsp_item_in.out_base       = base_ff;
                  rsp_item_in.is_insertion   = is_ins;
                  rsp_item_in.insertion_last = is_ins && done;
                  rsp_item_in.status         = STATUS_PLACED;
               end
            end
         end
         default: ;
      endcase
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[count_ff[IDX_W-1:0]] <= {req_item.element_kind, req_item.element_length};
      end
      rdata_ff <= table_mem[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CAE_IDLE;
         count_ff      <= '0;
         pointer_ff    <= '0;
         remain_ff     <= '0;
         column_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pointer_ff    <= pointer_in;
         remain_ff     <= remain_in;
         column_ff     <= column_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy       = (state_ff != CAE_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

// ===== tb/sv/cigar_alignment_expander_core_tb.sv =====
// ============================================================================
// cigar_alignment_expander_core_tb - self-checking bench for the CIGAR walker
// Drives start/append/base transactions through the start/busy handshake.
// A behavioral copy of the column walk predicts every result, and each
// strobed result is checked field by field in order. The run opens with a
// short directed table, then runs randomized reads in three idle profiles.
// ============================================================================
module cigar_alignment_expander_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cae_pkg::*;

   // Codes the package does not name
   localparam logic [1:0]        OP_UNKNOWN     = 2'd3;
   localparam logic [KIND_W-1:0] KIND_H         = 4'd5;
   localparam logic [KIND_W-1:0] KIND_P         = 4'd6;
   localparam logic [KIND_W-1:0] KIND_FIRST_BAD = 4'd9;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = MAX_ELEMENTS + 16;

   // One row of the directed table; want is used only when typed is set
   typedef struct packed {
      cae_req_type item;
      bit          typed;
      cae_rsp_type want;
   } vector_row_type;

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   logic        busy;
   cae_req_type req_item = '0;
   logic        rsp_strobe;
   cae_rsp_type rsp_item;

   cigar_alignment_expander_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the CIGAR table and walk position
   logic [KIND_W-1:0] kind_mem [MAX_ELEMENTS];
   logic [LEN_W-1:0]  len_mem  [MAX_ELEMENTS];
   int                elem_count = 0;
   int                elem_ptr   = 0;
   logic [LEN_W-1:0]  elem_left  = '0;
   logic [COL_W-1:0]  col        = '0;

   cae_rsp_type    expected_bases [$];
   vector_row_type dir_rows [$];

   int idle_pct        = 12;
   int items_done      = 0;
   int mismatch_cnt    = 0;
   int results_checked = 0;
   int overrun_cnt     = 0;
   int ins_close_cnt   = 0;
   int wrap_cnt        = 0;
   int full_drop_cnt   = 0;
   int clip_cnt        = 0;
   int cycle_count     = 0;

   // --------------------------------------------------------------------------
   // Column walk predictor
   // --------------------------------------------------------------------------
   function automatic void advance_column(input logic [COL_W-1:0] amount);
      logic [COL_W:0] sum;
      sum = {1'b0, col} + {1'b0, amount};
      if (sum[COL_W]) wrap_cnt++;
      col = sum[COL_W-1:0];
   endfunction

   // Walks the table for one base; returns 1 when the base makes a result
   function automatic bit expand_base(input logic [BASE_W-1:0] nib,
                                      output cae_rsp_type res);
      logic [KIND_W-1:0] k;
      logic [LEN_W-1:0]  n;
      bit                place;
      res                = '0;
      res.out_base       = nib;
      res.status         = STATUS_PLACED;
      while (elem_ptr < elem_count) begin
         k     = kind_mem[elem_ptr];
         n     = len_mem[elem_ptr];
         place = (k == KIND_M) || (k == KIND_EQ) || (k == KIND_X);
         // entering a new element: skip empties, D/N, H/P
         if (elem_left == '0) begin
            if (n == '0) begin
               elem_ptr++;
               continue;
            end
            if (k == KIND_D || k == KIND_N) begin
               advance_column(COL_W'(n));
               elem_ptr++;
               continue;
            end
            if (!(place || k == KIND_I || k == KIND_S)) begin
               elem_ptr++;
               continue;
            end
            elem_left = n;
         end
         elem_left  = elem_left - 1'b1;
         res.column = col;
         if (elem_left == '0) elem_ptr++;
         if (place) begin
            advance_column(COL_W'(1));
            return 1'b1;
         end
         if (k == KIND_I) begin
            res.is_insertion   = 1'b1;
            res.insertion_last = (elem_left == '0);
            if (elem_left == '0) advance_column(COL_W'(n));
            return 1'b1;
         end
         // soft clip swallows the base
         clip_cnt++;
         return 1'b0;
      end
      // table used up
      res.column = col;
      res.status = STATUS_OVERRUN;
      return 1'b1;
   endfunction

   // Updates the shadow state for an accepted transaction
   function automatic void accept_item(input cae_req_type item, input bit typed,
                                       input cae_rsp_type typed_rsp);
      cae_rsp_type res;
      items_done++;
      case (item.operation)
         OP_START: begin
            col        = {1'b0, item.start_column};
            elem_count = 0;
            elem_ptr   = 0;
            elem_left  = '0;
         end
         OP_APPEND: begin
            if (item.element_kind <= KIND_X) begin
               if (elem_count < MAX_ELEMENTS) begin
                  kind_mem[elem_count] = item.element_kind;
                  len_mem[elem_count]  = item.element_length;
                  elem_count++;
               end else begin
                  full_drop_cnt++;
               end
            end
         end
         OP_BASE: begin
            if (expand_base(item.base_nibble, res)) begin
               if (typed) res = typed_rsp;
               expected_bases = {expected_bases, res};
            end
         end
         default: ;
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Transaction builders; unused fields carry random bits
   // --------------------------------------------------------------------------
   function automatic cae_req_type noise_req();
      logic [95:0] r;
      r = {$urandom, $urandom, $urandom};
      return cae_req_type'(r[$bits(cae_req_type)-1:0]);
   endfunction

   function automatic cae_req_type req_start(input logic [30:0] c);
      cae_req_type item;
      item              = noise_req();
      item.operation    = OP_START;
      item.start_column = c;
      return item;
   endfunction

   function automatic cae_req_type req_append(input logic [KIND_W-1:0] k,
                                              input logic [LEN_W-1:0] len);
      cae_req_type item;
      item                = noise_req();
      item.operation      = OP_APPEND;
      item.element_kind   = k;
      item.element_length = len;
      return item;
   endfunction

   function automatic cae_req_type req_base(input logic [BASE_W-1:0] nib);
      cae_req_type item;
      item             = noise_req();
      item.operation   = OP_BASE;
      item.base_nibble = nib;
      return item;
   endfunction

   function automatic cae_req_type req_unknown();
      cae_req_type item;
      item           = noise_req();
      item.operation = OP_UNKNOWN;
      return item;
   endfunction

   function automatic cae_rsp_type overrun_at(input logic [COL_W-1:0] c,
                                              input logic [BASE_W-1:0] nib);
      cae_rsp_type res;
      res                = '0;
      res.column         = c;
      res.out_base       = nib;
      res.is_insertion   = 1'b0;
      res.insertion_last = 1'b0;
      res.status         = STATUS_OVERRUN;
      return res;
   endfunction

   // Adds one row to the end of the directed table
   function automatic void queue_row(input cae_req_type item,
                                     input bit typed = 1'b0,
                                     input cae_rsp_type want = '0);
      vector_row_type r;
      r.item   = item;
      r.typed  = typed;
      r.want   = want;
      dir_rows = {dir_rows, r};
   endfunction

   // --------------------------------------------------------------------------
   // Sender: optional idle gap, then hold the transaction until taken
   // --------------------------------------------------------------------------
   task automatic send_item(input cae_req_type item, input bit typed,
                            input cae_rsp_type typed_rsp);
      int gap;
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         start <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy !== 1'b0);
      accept_item(item, typed, typed_rsp);
   endtask

   task automatic send(input cae_req_type item);
      send_item(item, 1'b0, '0);
   endtask

   // Sender holds off until every predicted result is back
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_bases.size() != 0);
   endtask

   function automatic logic [KIND_W-1:0] pick_kind();
      if ($urandom_range(0, 9) == 0)
         return KIND_W'($urandom_range(KIND_FIRST_BAD, 15));
      return KIND_W'($urandom_range(KIND_M, KIND_X));
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      case ($urandom_range(0, 19))
         0, 1:    return '0;
         2:       return '1;
         3:       return LEN_W'($urandom);
         4, 5:    return LEN_W'($urandom_range(5, 12));
         default: return LEN_W'($urandom_range(1, 4));
      endcase
   endfunction

   // One read: start, CIGAR elements, then its bases plus a few extra
   task automatic random_read(input int read_no);
      int                n_elem;
      int                n_bases;
      int                consume;
      bit                wrap_mode;
      logic [30:0]       c;
      logic [KIND_W-1:0] k;
      logic [LEN_W-1:0]  len;
      wrap_mode = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 3))
         0:       c = '0;
         1:       c = '1;
         default: c = 31'($urandom);
      endcase
      if (wrap_mode) c = 31'h7FFF_FFFF - 31'($urandom_range(0, 7));
      send(req_start(c));
      // long D/N run pushes the column toward the 32-bit wrap
      if (wrap_mode)
         repeat (8) send(req_append($urandom_range(0, 1) ? KIND_D : KIND_N, '1));
      // every tenth read appends 60 to 70 elements, which can overfill the table
      n_elem  = (read_no % 10 == 3) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      consume = 0;
      for (int i = 0; i < n_elem; i++) begin
         k   = pick_kind();
         len = pick_length();
         send(req_append(k, len));
         if (k == KIND_M || k == KIND_I || k == KIND_S || k == KIND_EQ || k == KIND_X)
            consume += (len > 40) ? 40 : int'(len);
      end
      n_bases = ((consume > 30) ? 30 : consume) + $urandom_range(0, 2);
      for (int i = 0; i < n_bases; i++) begin
         case ($urandom_range(0, 39))
            0:       send(req_unknown());
            1:       send(req_append(pick_kind(), pick_length()));
            default: ;
         endcase
         send(req_base(BASE_W'($urandom)));
      end
   endtask

   // --------------------------------------------------------------------------
   // Result checking
   // --------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: result mismatch on %s: got 0x%0h, expected 0x%0h",
               $time, what, got, want);
      mismatch_cnt++;
   endtask

   always @(posedge clock) begin : result_check
      cae_rsp_type want;
      if (rsp_strobe === 1'b1) begin
         if (expected_bases.size() == 0) begin
            report_mismatch("unexpected result column", rsp_item.column, '0);
         end else begin
            want = expected_bases.pop_front();
            results_checked++;
            if (want.status == STATUS_OVERRUN) overrun_cnt++;
            if (want.insertion_last) ins_close_cnt++;
            if (rsp_item.column !== want.column)
               report_mismatch("column", rsp_item.column, want.column);
            if (rsp_item.out_base !== want.out_base)
               report_mismatch("out_base", 32'(rsp_item.out_base), 32'(want.out_base));
            if (rsp_item.is_insertion !== want.is_insertion)
               report_mismatch("is_insertion", 32'(rsp_item.is_insertion),
                               32'(want.is_insertion));
            if (rsp_item.insertion_last !== want.insertion_last)
               report_mismatch("insertion_last", 32'(rsp_item.insertion_last),
                               32'(want.insertion_last));
            if (rsp_item.status !== want.status)
               report_mismatch("status", 32'(rsp_item.status), 32'(want.status));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_bases.size());
         $display("cigar_alignment_expander_core_tb: errors");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin : stimulus
      int phase_end [3];
      int read_no;

      phase_end = '{240, 460, 690};
      read_no   = 0;

      // overrun straight after reset, unknown op, start at the top column
      queue_row(req_base(4'hA), 1'b1, overrun_at('0, 4'hA));
      queue_row(req_unknown());
      queue_row(req_start(31'h7FFF_FFFF));
      queue_row(req_base(4'h5), 1'b1, overrun_at(32'h7FFF_FFFF, 4'h5));
      // one element of every kind, bad kinds, zero and maximum lengths
      queue_row(req_append(KIND_M, 28'd2));
      queue_row(req_append(KIND_FIRST_BAD, 28'd5));
      queue_row(req_append(4'hF, 28'd1));
      queue_row(req_append(KIND_I, 28'd2));
      queue_row(req_append(KIND_D, 28'd0));
      queue_row(req_append(KIND_D, 28'hFFF_FFFF));
      queue_row(req_append(KIND_N, 28'd1));
      queue_row(req_append(KIND_S, 28'd1));
      queue_row(req_append(KIND_H, 28'd4));
      queue_row(req_append(KIND_P, 28'd2));
      queue_row(req_append(KIND_EQ, 28'd1));
      queue_row(req_append(KIND_X, 28'd1));
      // walk it: M M I I S = X, then past the end
      queue_row(req_base(4'h0));
      queue_row(req_base(4'hF));
      queue_row(req_base(4'h3));
      queue_row(req_base(4'hC));
      queue_row(req_base(4'h9));
      queue_row(req_base(4'h6));
      queue_row(req_base(4'h1));
      queue_row(req_base(4'hE));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

      // light sender idling, heavy idling, then back to back
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 12 : (phase == 1) ? 86 : 0;
         drain_results();
         while (items_done < phase_end[phase]) begin
            random_read(read_no);
            read_no++;
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d transactions in %0d reads, %0d results checked",
               items_done, read_no, results_checked);
      $display("  %0d past table end, %0d insertions closed, %0d wraps, %0d clips, %0d full drops",
               overrun_cnt, ins_close_cnt, wrap_cnt, clip_cnt, full_drop_cnt);
      if (mismatch_cnt == 0 && expected_bases.size() == 0) begin
         $display("cigar_alignment_expander_core_tb: clean");
      end else begin
         if (expected_bases.size() != 0)
            $display("%0d expected results never arrived", expected_bases.size());
         $display("cigar_alignment_expander_core_tb: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/cae_pkg.sv
sv/cigar_alignment_expander_core.sv
tb/sv/cigar_alignment_expander_core_tb.sv
